### design/ntt_pkg.sv
// ----------------------------------------------------------------------------
// ntt_pkg: shared types, constants and twiddle table
// modulus, scaling constant, command codes and payload structs for the ntt block
// ----------------------------------------------------------------------------
package ntt_pkg;

	localparam int COEFF_COUNT_DEF = 256;
	localparam logic [11:0] MOD_Q = 12'd3329;
	localparam logic [11:0] INV_SCALE = 12'd3303;

	typedef enum logic [1:0] {
		CMD_LOAD = 2'd0,
		CMD_XFORM = 2'd1,
		CMD_READ = 2'd2,
		CMD_NONE = 2'd3
	} cmd_t;

	typedef struct packed {
		logic [1:0] cmd;
		logic [7:0] index;
		logic [11:0] coeff_in;
	} in_item_t;

	typedef struct packed {
		logic [11:0] coeff_out;
		logic [7:0] index_out;
		logic done_res;
	} out_item_t;

	// operation handed from sequencer to arithmetic unit
	typedef enum logic [1:0] {
		OP_CT = 2'd0,
		OP_GS = 2'd1,
		OP_SCALE = 2'd2
	} op_t;

	// 17^bitrev7(k) mod 3329
	function automatic logic [11:0] zeta(input logic [6:0] k);
		logic [11:0] r;
		case (k)
			7'd0: r = 12'd1; 7'd1: r = 12'd1729; 7'd2: r = 12'd2580; 7'd3: r = 12'd3289;
			7'd4: r = 12'd2642; 7'd5: r = 12'd630; 7'd6: r = 12'd1897; 7'd7: r = 12'd848;
			7'd8: r = 12'd1062; 7'd9: r = 12'd1919; 7'd10: r = 12'd193; 7'd11: r = 12'd797;
			7'd12: r = 12'd2786; 7'd13: r = 12'd3260; 7'd14: r = 12'd569; 7'd15: r = 12'd1746;
			7'd16: r = 12'd296; 7'd17: r = 12'd2447; 7'd18: r = 12'd1339; 7'd19: r = 12'd1476;
			7'd20: r = 12'd3046; 7'd21: r = 12'd56; 7'd22: r = 12'd2240; 7'd23: r = 12'd1333;
			7'd24: r = 12'd1426; 7'd25: r = 12'd2094; 7'd26: r = 12'd535; 7'd27: r = 12'd2882;
			7'd28: r = 12'd2393; 7'd29: r = 12'd2879; 7'd30: r = 12'd1974; 7'd31: r = 12'd821;
			7'd32: r = 12'd289; 7'd33: r = 12'd331; 7'd34: r = 12'd3253; 7'd35: r = 12'd1756;
			7'd36: r = 12'd1197; 7'd37: r = 12'd2304; 7'd38: r = 12'd2277; 7'd39: r = 12'd2055;
			7'd40: r = 12'd650; 7'd41: r = 12'd1977; 7'd42: r = 12'd2513; 7'd43: r = 12'd632;
			7'd44: r = 12'd2865; 7'd45: r = 12'd33; 7'd46: r = 12'd1320; 7'd47: r = 12'd1915;
			7'd48: r = 12'd2319; 7'd49: r = 12'd1435; 7'd50: r = 12'd807; 7'd51: r = 12'd452;
			7'd52: r = 12'd1438; 7'd53: r = 12'd2868; 7'd54: r = 12'd1534; 7'd55: r = 12'd2402;
			7'd56: r = 12'd2647; 7'd57: r = 12'd2617; 7'd58: r = 12'd1481; 7'd59: r = 12'd648;
			7'd60: r = 12'd2474; 7'd61: r = 12'd3110; 7'd62: r = 12'd1227; 7'd63: r = 12'd910;
			7'd64: r = 12'd17; 7'd65: r = 12'd2761; 7'd66: r = 12'd583; 7'd67: r = 12'd2649;
			7'd68: r = 12'd1637; 7'd69: r = 12'd723; 7'd70: r = 12'd2288; 7'd71: r = 12'd1100;
			7'd72: r = 12'd1409; 7'd73: r = 12'd2662; 7'd74: r = 12'd3281; 7'd75: r = 12'd233;
			7'd76: r = 12'd756; 7'd77: r = 12'd2156; 7'd78: r = 12'd3015; 7'd79: r = 12'd3050;
			7'd80: r = 12'd1703; 7'd81: r = 12'd1651; 7'd82: r = 12'd2789; 7'd83: r = 12'd1789;
			7'd84: r = 12'd1847; 7'd85: r = 12'd952; 7'd86: r = 12'd1461; 7'd87: r = 12'd2687;
			7'd88: r = 12'd939; 7'd89: r = 12'd2308; 7'd90: r = 12'd2437; 7'd91: r = 12'd2388;
			7'd92: r = 12'd733; 7'd93: r = 12'd2337; 7'd94: r = 12'd268; 7'd95: r = 12'd641;
			7'd96: r = 12'd1584; 7'd97: r = 12'd2298; 7'd98: r = 12'd2037; 7'd99: r = 12'd3220;
			7'd100: r = 12'd375; 7'd101: r = 12'd2549; 7'd102: r = 12'd2090; 7'd103: r = 12'd1645;
			7'd104: r = 12'd1063; 7'd105: r = 12'd319; 7'd106: r = 12'd2773; 7'd107: r = 12'd757;
			7'd108: r = 12'd2099; 7'd109: r = 12'd561; 7'd110: r = 12'd2466; 7'd111: r = 12'd2594;
			7'd112: r = 12'd2804; 7'd113: r = 12'd1092; 7'd114: r = 12'd403; 7'd115: r = 12'd1026;
			7'd116: r = 12'd1143; 7'd117: r = 12'd2150; 7'd118: r = 12'd2775; 7'd119: r = 12'd886;
			7'd120: r = 12'd1722; 7'd121: r = 12'd1212; 7'd122: r = 12'd1874; 7'd123: r = 12'd1029;
			7'd124: r = 12'd2110; 7'd125: r = 12'd2935; 7'd126: r = 12'd885; 7'd127: r = 12'd2154;
			default: r = 12'd1;
		endcase
		return r;
	endfunction

	// a+b mod q for a,b < q
	function automatic logic [11:0] mod_add(input logic [11:0] a, input logic [11:0] b);
		logic [12:0] s;
		logic [12:0] d;
		s = {1'b0, a} + {1'b0, b};
		d = s - {1'b0, MOD_Q};
		return d[12] ? s[11:0] : d[11:0];
	endfunction

	// a-b mod q for a,b < q
	function automatic logic [11:0] mod_sub(input logic [11:0] a, input logic [11:0] b);
		logic [12:0] d;
		logic [12:0] e;
		d = {1'b0, a} - {1'b0, b};
		e = d + {1'b0, MOD_Q};
		return d[12] ? e[11:0] : d[11:0];
	endfunction

endpackage

### design/ntt_forward_inverse_q3329.sv
// ----------------------------------------------------------------------------
// ntt_forward_inverse_q3329: in-place forward / inverse ntt over z_3329
// 256-coefficient store with a single shared butterfly under a sequencer
// ----------------------------------------------------------------------------
// a command transfer is taken when start is high and busy is low. a load is
// written into the store at its transfer edge and busy stays low, so loads can
// follow back to back. a read keeps busy high through its read state and its data is
// strobed by result_valid in the cycle after that state. a transform walks seven
// layers of 128 butterflies through one shared multiply-reduce unit: each
// butterfly steps through two memory reads, the two-stage multiplier and a write
// back of two words through the single write port, and an inverse run adds a
// 256-entry scaling pass that reads, scales and writes back each coefficient.
// the done result is strobed in the same cycle as busy drops. result_valid is
// high for exactly one cycle per result and the receiver cannot stall it. the
// store is cleared after reset by a pass over all 256 entries, with busy high.
module ntt_forward_inverse_q3329 #(
	parameter int COEFF_COUNT = ntt_pkg::COEFF_COUNT_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input ntt_pkg::in_item_t cmd_in,
	input logic cfg_we,
	input logic cfg_wdata,
	output logic result_valid,
	output ntt_pkg::out_item_t result
);
	localparam int AW = $clog2(COEFF_COUNT);

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_READ, S_BF_RA, S_BF_RB, S_BF_M1, S_BF_M2, S_BF_M3,
		S_BF_WB, S_SC_R, S_SC_M1, S_SC_M2, S_SC_M3, S_DONE
	} state_t;

	state_t state_q;
	logic inv_q;
	logic [11:0] mem_q [COEFF_COUNT];
	logic [11:0] rdata_q;
	logic [AW-1:0] raddr;
	logic we;
	logic [AW-1:0] waddr;
	logic [11:0] wdata;

	logic [2:0] layer_q; // 0..6
	logic [AW-2:0] bf_q; // butterfly within layer
	logic [AW-1:0] cnt_q; // clear / scale sweep
	logic [11:0] a_q, b_q, hi_q;
	logic [11:0] mul_a, mul_b, mul_p;
	logic [11:0] b_cur;
	logic [6:0] k_idx;
	logic [AW-1:0] ja, jb;
	logic [2:0] lg; // log2(len)
	logic [11:0] sub_ld;

	// len = 128 >> layer (forward) or 2 << layer (inverse)
	always_comb begin
		lg = inv_q ? 3'(layer_q + 3'd1) : 3'(3'd7 - layer_q);
		ja = ((AW'(bf_q) >> lg) << (4'(lg) + 4'd1)) | (AW'(bf_q) & ((AW'(1) << lg) - AW'(1)));
		jb = ja | (AW'(1) << lg);
		// twiddle index: forward k = 2^layer + group, inverse k = 127 - (offset + group)
		if (inv_q) begin
			k_idx = 7'(7'd127 - 7'((8'd128 - (8'd128 >> layer_q))) - 7'(bf_q >> lg));
		end else begin
			k_idx = 7'((7'd1 << layer_q) + 7'(bf_q >> lg));
		end
	end

	// shared multiplier operands; the upper word is taken straight from the
	// read port in its first cycle so the product is ready for the write back
	always_comb begin
		b_cur = (state_q == S_BF_M1) ? rdata_q : b_q;
		mul_a = ntt_pkg::zeta(k_idx);
		mul_b = inv_q ? ntt_pkg::mod_sub(b_cur, a_q) : b_cur;
		if (state_q == S_SC_M1 || state_q == S_SC_M2 || state_q == S_SC_M3) begin
			mul_a = ntt_pkg::INV_SCALE;
			mul_b = (state_q == S_SC_M1) ? rdata_q : a_q;
		end
	end

	ntt_mulred u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(mul_p));

	always_comb begin
		raddr = cmd_in.index;
		unique case (state_q)
			S_BF_RA: raddr = ja;
			S_BF_RB: raddr = jb;
			S_SC_R: raddr = cnt_q;
			default: raddr = cmd_in.index;
		endcase
	end

	always_comb begin
		sub_ld = cmd_in.coeff_in;
		if (cmd_in.coeff_in >= ntt_pkg::MOD_Q) begin
			sub_ld = cmd_in.coeff_in - ntt_pkg::MOD_Q;
		end
		we = 1'b0;
		waddr = cmd_in.index;
		wdata = sub_ld;
		unique case (state_q)
			S_CLEAR: begin
				we = 1'b1; waddr = cnt_q; wdata = '0;
			end
			S_IDLE: we = start && (cmd_in.cmd == ntt_pkg::CMD_LOAD);
			S_BF_M3: begin
				we = 1'b1; waddr = ja;
				wdata = inv_q ? ntt_pkg::mod_add(a_q, b_q) : ntt_pkg::mod_add(a_q, mul_p);
			end
			S_BF_WB: begin
				we = 1'b1; waddr = jb; wdata = hi_q;
			end
			S_SC_M3: begin
				we = 1'b1; waddr = cnt_q; wdata = mul_p;
			end
			default: we = 1'b0;
		endcase
	end

	// one write port and one read port, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			inv_q <= 1'b0;
			cnt_q <= '0;
			layer_q <= '0;
			bf_q <= '0;
			result_valid <= 1'b0;
		end else begin
			result_valid <= 1'b0;
			if (cfg_we) begin
				inv_q <= cfg_wdata;
			end
			unique case (state_q)
				S_CLEAR: begin
					cnt_q <= cnt_q + AW'(1);
					if (cnt_q == AW'(COEFF_COUNT - 1)) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (start) begin
						if (cmd_in.cmd == ntt_pkg::CMD_READ) begin
							state_q <= S_READ;
							result.index_out <= cmd_in.index;
						end else if (cmd_in.cmd == ntt_pkg::CMD_XFORM) begin
							state_q <= S_BF_RA;
							layer_q <= '0;
							bf_q <= '0;
						end
					end
				end
				S_READ: begin
					result_valid <= 1'b1;
					result.coeff_out <= rdata_q;
					result.done_res <= 1'b0;
					state_q <= S_IDLE;
				end
				S_BF_RA: state_q <= S_BF_RB;
				S_BF_RB: begin
					a_q <= rdata_q;
					state_q <= S_BF_M1;
				end
				S_BF_M1: begin
					b_q <= rdata_q;
					state_q <= S_BF_M2;
				end
				S_BF_M2: state_q <= S_BF_M3;
				S_BF_M3: begin
					hi_q <= inv_q ? mul_p : ntt_pkg::mod_sub(a_q, mul_p);
					state_q <= S_BF_WB;
				end
				S_BF_WB: begin
					bf_q <= bf_q + (AW-1)'(1);
					state_q <= S_BF_RA;
					if (bf_q == '1) begin
						layer_q <= layer_q + 3'd1;
						if (layer_q == 3'd6) begin
							cnt_q <= '0;
							state_q <= inv_q ? S_SC_R : S_DONE;
						end
					end
				end
				S_SC_R: state_q <= S_SC_M1;
				S_SC_M1: begin
					a_q <= rdata_q;
					state_q <= S_SC_M2;
				end
				S_SC_M2: state_q <= S_SC_M3;
				S_SC_M3: begin
					cnt_q <= cnt_q + AW'(1);
					state_q <= (cnt_q == AW'(COEFF_COUNT - 1)) ? S_DONE : S_SC_R;
				end
				S_DONE: begin
					result_valid <= 1'b1;
					result.coeff_out <= '0;
					result.index_out <= '0;
					result.done_res <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);

`ifndef SYNTH
	// a result transfer always follows a busy cycle
	a_res_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(busy)) else $error("result without work");
	// result data always stays below the modulus
	a_res_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.coeff_out < ntt_pkg::MOD_Q) else $error("coeff out of range");
	// a done result carries zero payload
	a_done_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.done_res) |-> (result.coeff_out == '0))
		else $error("done result payload");
`endif
endmodule

### design/ntt_mulred.sv
// ----------------------------------------------------------------------------
// ntt_mulred: registered modular multiplier
// two-stage product then barrett reduction modulo 3329
// ----------------------------------------------------------------------------
module ntt_mulred (
	input logic clk,
	input logic [11:0] a,
	input logic [11:0] b,
	output logic [11:0] p
);
	logic [23:0] prod_s1;
	logic [23:0] prod_s2;
	logic [23:0] qt_s2;
	logic [37:0] est;
	logic [24:0] rem1;
	logic [24:0] rem2;

	// floor(2^24/3329)=5039; estimate low by at most two
	assign est = 38'(prod_s1) * 38'd5039;

	always_ff @(posedge clk) begin
		prod_s1 <= 24'(a) * 24'(b);
		prod_s2 <= prod_s1;
		qt_s2 <= est[37:24] * 24'(ntt_pkg::MOD_Q);
	end

	always_comb begin
		rem1 = 25'(prod_s2) - 25'(qt_s2);
		rem2 = rem1;
		if (rem2 >= 25'(ntt_pkg::MOD_Q)) begin
			rem2 = rem2 - 25'(ntt_pkg::MOD_Q);
		end
		if (rem2 >= 25'(ntt_pkg::MOD_Q)) begin
			rem2 = rem2 - 25'(ntt_pkg::MOD_Q);
		end
		p = rem2[11:0];
	end
endmodule

### sim/ntt_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntt_result_checker: coefficient store shadow and result comparison
// mirrors every accepted command transfer into its own copy of the polynomial,
// predicts read data and transform completions, and compares each result
// ----------------------------------------------------------------------------
module ntt_result_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input ntt_pkg::in_item_t cmd_in,
	input logic cfg_we,
	input logic cfg_wdata,
	input logic result_valid,
	input ntt_pkg::out_item_t result,
	output int fail_count,
	output int pending
);
	localparam int Q = 3329;

	logic [11:0] shadow_poly [256];
	logic [11:0] twiddle [128];
	logic inverse_sel;
	ntt_pkg::out_item_t expected_results [$];

	// 17^bitrev7(k) mod q
	initial begin
		int pw [128];
		int r;
		pw[0] = 1;
		for (int k = 1; k < 128; k++) pw[k] = (pw[k - 1] * 17) % Q;
		for (int k = 0; k < 128; k++) begin
			r = 0;
			for (int b = 0; b < 7; b++) r = (r << 1) | ((k >> b) & 1);
			twiddle[k] = 12'(pw[r]);
		end
	end

	task automatic transform_shadow();
		int k, a, b, t, z;
		if (!inverse_sel) begin
			k = 1;
			for (int len = 128; len >= 2; len >>= 1) begin
				for (int s = 0; s < 256; s += 2 * len) begin
					z = int'(twiddle[k & 127]);
					k++;
					for (int j = s; j < s + len; j++) begin
						t = (z * int'(shadow_poly[j + len])) % Q;
						a = int'(shadow_poly[j]);
						shadow_poly[j + len] = 12'((a - t + Q) % Q);
						shadow_poly[j] = 12'((a + t) % Q);
					end
				end
			end
		end else begin
			k = 127;
			for (int len = 2; len <= 128; len <<= 1) begin
				for (int s = 0; s < 256; s += 2 * len) begin
					z = int'(twiddle[k & 127]);
					k--;
					for (int j = s; j < s + len; j++) begin
						a = int'(shadow_poly[j]);
						b = int'(shadow_poly[j + len]);
						shadow_poly[j] = 12'((a + b) % Q);
						shadow_poly[j + len] = 12'((z * ((b - a + Q) % Q)) % Q);
					end
				end
			end
			for (int j = 0; j < 256; j++)
				shadow_poly[j] = 12'((int'(shadow_poly[j]) * 3303) % Q);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		ntt_pkg::out_item_t exp_item;
		logic [11:0] v;
		if (!arst_n) begin
			for (int i = 0; i < 256; i++) shadow_poly[i] = '0;
			inverse_sel = 1'b0;
			expected_results.delete();
			fail_count = 0;
		end else begin
			if (result_valid) begin
				if (expected_results.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result: coeff %0d index %0d done %0d",
							result.coeff_out, result.index_out, result.done_res);
				end else begin
					exp_item = expected_results.pop_front();
					if (result !== exp_item) begin
						fail_count++;
						if (fail_count <= 10)
							$display("mismatch: exp coeff %0d index %0d done %0d, got %0d %0d %0d",
								exp_item.coeff_out, exp_item.index_out, exp_item.done_res,
								result.coeff_out, result.index_out, result.done_res);
					end
				end
			end
			if (cfg_we) inverse_sel = cfg_wdata;
			if (start && !busy) begin
				case (ntt_pkg::cmd_t'(cmd_in.cmd))
					ntt_pkg::CMD_LOAD: begin
						v = cmd_in.coeff_in;
						if (v >= 12'd3329) v = v - 12'd3329;
						shadow_poly[cmd_in.index] = v;
					end
					ntt_pkg::CMD_XFORM: begin
						transform_shadow();
						expected_results.push_back(ntt_pkg::out_item_t'{coeff_out: '0,
							index_out: '0, done_res: 1'b1});
					end
					ntt_pkg::CMD_READ: expected_results.push_back(ntt_pkg::out_item_t'{
						coeff_out: shadow_poly[cmd_in.index],
						index_out: cmd_in.index, done_res: 1'b0});
					default: ;
				endcase
			end
		end
		pending = expected_results.size();
	end
endmodule

### sim/ntt_forward_inverse_q3329_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntt_forward_inverse_q3329_test: command stimulus and verdict
// directed corner commands, then random load / read / transform traffic under
// three sender idling regimes with the mode bit redrawn between segments
// ----------------------------------------------------------------------------
module ntt_forward_inverse_q3329_test;
	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	ntt_pkg::in_item_t cmd_in;
	logic cfg_we;
	logic cfg_wdata;
	logic result_valid;
	ntt_pkg::out_item_t result;
	int fail_count;
	int pending;
	int idle_pct;

	ntt_forward_inverse_q3329 uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd_in(cmd_in),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .result_valid(result_valid), .result(result)
	);

	// checker sits beside the block and only watches
	ntt_result_checker chk (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd_in(cmd_in),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .result_valid(result_valid), .result(result),
		.fail_count(fail_count), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// hard stop well beyond the slowest correct run (a few dozen transforms
	// plus the load / read traffic)
	initial begin
		#20ms;
		$display("TB_ERROR");
		$finish;
	end

	// one command transfer; may insert an idle gap first
	task automatic send(input ntt_pkg::cmd_t c, input logic [7:0] idx,
		input logic [11:0] val);
		if ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		start <= 1'b1;
		cmd_in <= '{cmd: c, index: idx, coeff_in: val};
		// transfer completes at the edge where busy was seen low
		do @(posedge clk); while (busy);
	endtask

	// mode change only with nothing in flight; loads leave no result behind,
	// so let the load latency pass and busy drop too
	task automatic set_mode(input logic m);
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		while (busy) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= m;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic random_item();
		int sel;
		logic [11:0] v;
		sel = $urandom_range(0, 999);
		v = ($urandom_range(0, 9) == 0) ? 12'($urandom_range(3329, 4095))
			: 12'($urandom_range(0, 3328));
		if (sel < 12) send(ntt_pkg::CMD_XFORM, 8'($urandom), 12'($urandom));
		else if (sel < 40) send(ntt_pkg::CMD_NONE, 8'($urandom), 12'($urandom));
		else if (sel < 620) send(ntt_pkg::CMD_LOAD, 8'($urandom), v);
		else send(ntt_pkg::CMD_READ, 8'($urandom), 12'($urandom));
	endtask

	initial begin
		int lim;
		arst_n = 1'b0;
		start = 1'b0;
		cmd_in = '0;
		cfg_we = 1'b0;
		cfg_wdata = 1'b0;
		idle_pct = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// directed corners: range extremes, out-of-range loads, unused command,
		// reads after clear, both transform directions
		set_mode(1'b0);
		send(ntt_pkg::CMD_READ, 8'd7, 12'd0);
		send(ntt_pkg::CMD_LOAD, 8'd0, 12'd0);
		send(ntt_pkg::CMD_LOAD, 8'd255, 12'd3328);
		send(ntt_pkg::CMD_LOAD, 8'd1, 12'd3329);
		send(ntt_pkg::CMD_LOAD, 8'd2, 12'd4095);
		send(ntt_pkg::CMD_LOAD, 8'd3, 12'd1);
		send(ntt_pkg::CMD_NONE, 8'd3, 12'd4095);
		send(ntt_pkg::CMD_READ, 8'd1, 12'd0);
		send(ntt_pkg::CMD_READ, 8'd2, 12'd0);
		send(ntt_pkg::CMD_READ, 8'd255, 12'd0);
		send(ntt_pkg::CMD_XFORM, 8'd0, 12'd0);
		send(ntt_pkg::CMD_READ, 8'd0, 12'd0);
		send(ntt_pkg::CMD_READ, 8'd128, 12'd0);
		set_mode(1'b1);
		send(ntt_pkg::CMD_XFORM, 8'd0, 12'd0);
		send(ntt_pkg::CMD_READ, 8'd2, 12'd0);
		send(ntt_pkg::CMD_READ, 8'd255, 12'd0);

		// three idling regimes, mode redrawn every segment of about 150 transfers
		for (int ph = 0; ph < 3; ph++) begin
			idle_pct = (ph == 0) ? 18 : (ph == 1) ? 78 : 0;
			for (int seg = 0; seg < 4; seg++) begin
				set_mode(1'($urandom));
				lim = 140 + $urandom_range(0, 20);
				for (int n = 0; n < lim; n++) random_item();
				send(ntt_pkg::CMD_XFORM, 8'd0, 12'd0);
				send(ntt_pkg::CMD_READ, 8'($urandom), 12'd0);
			end
		end

		start <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end
endmodule
